FILE: rtl/vzd_pkg.sv
// Package for the varint / zigzag / delta decoder.
// Shared widths, constants and the accumulator-to-delta struct. No dependencies.
`default_nettype none

package vzd_pkg;

  localparam int unsigned WordBits   = 64;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned GroupBits  = 7;
  localparam int unsigned OffsetBits = 7;
  localparam int unsigned MoreBit    = 7;

  localparam logic [ByteBits-1:0]   PayloadMask = 8'h7F;
  localparam logic [OffsetBits-1:0] GroupStep   = 7'd7;
  localparam logic [OffsetBits-1:0] OffsetCap   = 7'd70;

  typedef logic [WordBits-1:0] word_t;

  // finished number handed from the accumulator to the delta stage
  typedef struct packed {
    logic  last;
    word_t word;
  } acc_word_t;

endpackage

`default_nettype wire

FILE: rtl/vzd_accum.sv
// Varint accumulator: gathers 7-bit groups into a 64-bit word.
// Depends on vzd_pkg.
`default_nettype none

module vzd_accum (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [vzd_pkg::ByteBits-1:0]  data_byte_i,
  output vzd_pkg::acc_word_t                 acc_o
);

  vzd_pkg::word_t                    partial_sum_q, partial_sum_d;
  logic [vzd_pkg::OffsetBits-1:0]    bit_offset_q, bit_offset_d;
  vzd_pkg::word_t                    group_ext;
  vzd_pkg::word_t                    shifted;
  vzd_pkg::word_t                    merged;
  logic                              in_range;
  logic                              last;

  assign in_range  = ~bit_offset_q[vzd_pkg::OffsetBits-1];  // offset < 64
  assign last      = ~data_byte_i[vzd_pkg::MoreBit];
  assign group_ext = vzd_pkg::word_t'(data_byte_i & vzd_pkg::PayloadMask);
  assign shifted   = group_ext << bit_offset_q[vzd_pkg::OffsetBits-2:0];
  assign merged    = in_range ? (partial_sum_q | shifted) : partial_sum_q;

  assign acc_o.last = last;
  assign acc_o.word = merged;

  always_comb begin
    partial_sum_d = partial_sum_q;
    bit_offset_d  = bit_offset_q;
    if (step_i) begin
      if (last) begin
        partial_sum_d = '0;
        bit_offset_d  = '0;
      end else begin
        partial_sum_d = merged;
        // offset sticks at 70 once past the word
        if (in_range) begin
          bit_offset_d = bit_offset_q + vzd_pkg::GroupStep;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_sum_q <= '0;
      bit_offset_q  <= '0;
    end else begin
      partial_sum_q <= partial_sum_d;
      bit_offset_q  <= bit_offset_d;
    end
  end

`ifndef ASSERT_OFF
  a_offset_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_offset_q <= vzd_pkg::OffsetCap)
    else $error("bit offset beyond cap");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last |=> bit_offset_q == '0 && partial_sum_q == '0)
    else $error("accumulator not cleared after last byte");

  a_offset_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last && in_range |=> bit_offset_q == $past(bit_offset_q) + vzd_pkg::GroupStep)
    else $error("offset did not advance by one group");
`endif

endmodule

`default_nettype wire

FILE: rtl/vzd_delta.sv
// Zigzag decode and delta reconstruction, plus the delta_mode register.
// Depends on vzd_pkg.
`default_nettype none

module vzd_delta (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_mode_i,
  input  wire logic                 fire_i,
  input  wire vzd_pkg::acc_word_t   acc_i,
  output vzd_pkg::word_t            value_o
);

  logic           delta_mode_q;
  logic           first_pending_q, first_pending_d;
  vzd_pkg::word_t running_total_q, running_total_d;
  vzd_pkg::word_t decoded;
  vzd_pkg::word_t total_next;

  assign decoded    = (acc_i.word >> 1) ^ {vzd_pkg::WordBits{acc_i.word[0]}};
  assign total_next = first_pending_q ? decoded : (running_total_q + decoded);
  assign value_o    = delta_mode_q ? total_next : decoded;

  always_comb begin
    first_pending_d = first_pending_q;
    running_total_d = running_total_q;
    if (fire_i && delta_mode_q) begin
      first_pending_d = 1'b0;
      running_total_d = total_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_mode_q    <= 1'b1;
      first_pending_q <= 1'b1;
      running_total_q <= '0;
    end else begin
      if (cfg_we_i) begin
        delta_mode_q <= cfg_mode_i;
      end
      first_pending_q <= first_pending_d;
      running_total_q <= running_total_d;
    end
  end

`ifndef ASSERT_OFF
  a_first_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && delta_mode_q |=> !first_pending_q)
    else $error("first_pending still set after delta value");

  a_direct_keeps_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(running_total_q) && $stable(first_pending_q))
    else $error("delta state changed without a completed number");

  a_total_is_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && delta_mode_q |=> running_total_q == $past(value_o))
    else $error("running total differs from emitted value");

  a_fire_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> acc_i.last)
    else $error("delta stage fired on a continuation byte");
`endif

endmodule

`default_nettype wire

FILE: rtl/varint_zigzag_delta_decoder_unit.sv
// Top level of the varint / zigzag / delta decoder: input and result registers.
// Depends on vzd_pkg, vzd_accum and vzd_delta.
//
//   channel | signals                              | payload
//   --------+--------------------------------------+-------------------------
//   in      | in_valid_i, in_stall_o               | data_byte_i [7:0]
//   out     | out_valid_o, out_stall_i             | value_o [63:0] signed
//   cfg     | cfg_valid_i, cfg_ready_o (always 1)  | delta_mode_i
//
// One byte per cycle sustained unless a final byte is held back by out_stall_i.
// A byte is registered, then decoded against the accumulator and delta state,
// and a finished number lands in the result register. While a result waits
// under out_stall_i, continuation bytes still drain; a final byte waits in the
// input register and in_stall_o rises behind it.
// Reset clears all state but data_byte_q and value_q; delta_mode comes up as 1.
`default_nettype none

module varint_zigzag_delta_decoder_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [vzd_pkg::ByteBits-1:0]  data_byte_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [vzd_pkg::WordBits-1:0] value_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic                          delta_mode_i
);

  logic                           in_valid_q;
  logic [vzd_pkg::ByteBits-1:0]   data_byte_q;
  logic                           out_valid_q;
  vzd_pkg::word_t                 value_q;
  vzd_pkg::word_t                 value_next;
  vzd_pkg::acc_word_t             acc;
  logic                           completes;
  logic                           out_free;
  logic                           proceed;
  logic                           emit;
  logic                           accept;

  assign completes = ~data_byte_q[vzd_pkg::MoreBit];
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign proceed   = in_valid_q & (~completes | out_free);
  assign emit      = proceed & completes;

  assign in_stall_o  = in_valid_q & ~proceed;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  vzd_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (proceed),
    .data_byte_i (data_byte_q),
    .acc_o       (acc)
  );

  vzd_delta u_delta (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_mode_i (delta_mode_i),
    .fire_i     (emit),
    .acc_i      (acc),
    .value_o    (value_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (proceed) begin
        in_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_byte_q <= data_byte_i;
    end
    if (emit) begin
      value_q <= value_next;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && completes && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked final byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !emit)
    else $error("result register overwritten while held");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q && value_q == $past(value_next))
    else $error("completed number not captured");
`endif

endmodule

`default_nettype wire

FILE: dv/vzd_checker.sv
// Scoreboard for the varint / zigzag / delta decoder: follows the byte, config and
// result channels, predicts each finished number and compares it with the DUT result.
// Depends on vzd_pkg.
`timescale 1ns / 100ps

module vzd_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic [vzd_pkg::ByteBits-1:0] data_byte_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic [vzd_pkg::WordBits-1:0] value_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic                         cfg_ready_i,
  input  wire logic                         delta_mode_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       numbers_o
);

  // predictor state
  logic                           delta_on;
  vzd_pkg::word_t                 acc_word;
  logic [vzd_pkg::OffsetBits-1:0] shift_amt;
  logic                           first_num;
  vzd_pkg::word_t                 run_total;
  vzd_pkg::word_t                 value_q[$];

  int unsigned fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vzd_pkg::word_t want;
    vzd_pkg::word_t decoded;
    if (!rst_ni) begin
      delta_on  = 1'b1;
      acc_word  = '0;
      shift_amt = '0;
      first_num = 1'b1;
      run_total = '0;
      value_q.delete();
      pending_o <= 0;
      numbers_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) delta_on = delta_mode_i;

      if (out_valid_i && !out_stall_i) begin
        numbers_o <= numbers_o + 1;
        if (value_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", value_i));
        end else begin
          want = value_q.pop_front();
          if (value_i !== want)
            report_mismatch($sformatf("value got %h exp %h", value_i, want));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        // groups past bit 63 are dropped; offset parks at 70
        if (shift_amt < vzd_pkg::WordBits)
          acc_word |= vzd_pkg::word_t'(data_byte_i & vzd_pkg::PayloadMask) << shift_amt;
        if (data_byte_i[vzd_pkg::MoreBit]) begin
          if (shift_amt < vzd_pkg::WordBits) shift_amt += vzd_pkg::GroupStep;
        end else begin
          decoded   = (acc_word >> 1) ^ {vzd_pkg::WordBits{acc_word[0]}};
          acc_word  = '0;
          shift_amt = '0;
          if (delta_on) begin
            run_total = first_num ? decoded : run_total + decoded;
            first_num = 1'b0;
            value_q   = {value_q, run_total};
          end else begin
            value_q   = {value_q, decoded};
          end
        end
      end

      pending_o <= value_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Top of the decoder testbench: clock, reset, byte/config stimulus and result stall.
// Depends on vzd_pkg, varint_zigzag_delta_decoder_unit and vzd_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned Settle     = 4;   // result lags behind input; plus margin
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseBytes = 114;

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic [vzd_pkg::ByteBits-1:0] data_byte   = '0;
  logic                         out_stall   = 1'b0;
  logic                         cfg_valid   = 1'b0;
  logic                         mode_bit    = 1'b0;
  logic                         calm        = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic                         cfg_ready;
  logic [vzd_pkg::WordBits-1:0] value;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned numbers;
  int unsigned cycles      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned mode_writes = 0;
  int unsigned hold_left   = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  varint_zigzag_delta_decoder_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .delta_mode_i(mode_bit)
  );

  vzd_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .data_byte_i (data_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .value_i     (value),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .delta_mode_i(mode_bit),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .numbers_o   (numbers)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: after each transaction, draw whether and how long to hold stall (none when calm)
  always @(posedge clk or negedge rst_n) begin
    int unsigned hold_draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold_draw = calm ? 0 : $urandom_range(0, 3);
      hold_left <= hold_draw;
      out_stall <= (hold_draw != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  task automatic send_byte(input logic [vzd_pkg::ByteBits-1:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // hold off input until every predicted number has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    mode_bit  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  initial begin
    // zero, -64, -1, min int (10 bytes), max int with stray bits above bit 63
    logic [vzd_pkg::ByteBits-1:0] opening[$] = '{
      8'h00, 8'h7F, 8'h01,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
      8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F
    };
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    logic [31:0] rnd;
    logic [vzd_pkg::GroupBits-1:0] low;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delta mode out of reset: first value passes, later ones accumulate and wrap
    foreach (opening[i]) send_byte(opening[i]);
    // leave a number half done, switch to direct mode, then finish it
    send_byte(8'h81);
    drain();
    write_mode(1'b0);
    send_byte(8'h01);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
      calm = (ph == 3) || ($urandom_range(0, 4) == 0);
      sent = 0;
      while (sent < PhaseBytes) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          send_byte(8'($urandom));
          sent++;
        end else begin
          len = (kind < 70) ? $urandom_range(1, 3) :
                (kind < 92) ? $urandom_range(4, 10) : $urandom_range(11, 14);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
              low = $urandom_range(0, 1) ? '1 : '0;
            end else begin
              rnd = $urandom();
              low = rnd[vzd_pkg::GroupBits-1:0];
            end
            send_byte({k != len - 1, low});
            sent++;
          end
        end
      end
      drain();
    end
    calm = 1'b0;

    $display("Run: %0d bytes in, %0d numbers compared, %0d mode writes",
             bytes_sent, numbers, mode_writes);
    $display("Delta and direct modes, 64-bit extremes, overlong and mid-number mode switch");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
